FILE: hdl/nnd_pkg.sv
package nnd_pkg;

  localparam int MAX_DIM_DEF = 16384;
  localparam int REG_W       = 15;
  localparam int PIX_W       = 32;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  typedef enum logic [1:0] {
    REG_SRC_W,
    REG_SRC_H,
    REG_MAX_SIDE
  } reg_idx_t;

  typedef struct packed {
    logic size_load;
    logic size_take;
    logic px_accept;
  } nnd_cmd_t;

  typedef struct packed {
    logic img_start;
    logic img_wrap;
    logic pass_thru;
    logic div_done;
    logic out_free;
  } nnd_sts_t;

endpackage

FILE: hdl/nnd_in_if.sv
interface nnd_in_if;
  logic                       valid;
  logic                       ready;
  logic [nnd_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

FILE: hdl/nnd_out_if.sv
interface nnd_out_if;
  logic                       valid;
  logic                       ready;
  logic [nnd_pkg::PIX_W-1:0]  pixel_out;
  logic                       last_of_image;

  modport source (output valid, output pixel_out, output last_of_image, input ready);
  modport sink (input valid, input pixel_out, input last_of_image, output ready);
endinterface

FILE: hdl/nearest_neighbor_downscaler.sv
// A selected pixel sits in the output register in the cycle after its input beat.
// Throughput: one input beat per cycle within an image, while the output register is free or being read.
// At each image start the first beat waits while the sizes latch: in passthrough it waits in the start
// state only; otherwise it also waits in the divide state until the size divide is done.
// Reset (rst_n low, synchronous) clears position and sizes; registers go to 1, 1, 0.
module nearest_neighbor_downscaler #(
  parameter int MAX_DIM = nnd_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  nnd_in_if.sink                        in_px,
  nnd_out_if.source                     out_px,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nnd_pkg::PADDR_W-1:0]   paddr,
  input  logic [nnd_pkg::PDATA_W-1:0]   pwdata,
  output logic [nnd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [nnd_pkg::REG_W-1:0] src_w, src_h, max_side;
  logic                      cfg_wr;
  logic                      in_ready;
  nnd_pkg::nnd_cmd_t         cmd;
  nnd_pkg::nnd_sts_t         sts;

  nnd_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .src_w    (src_w),
    .src_h    (src_h),
    .max_side (max_side),
    .cfg_wr   (cfg_wr)
  );

  nnd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_px.valid),
    .cfg_wr   (cfg_wr),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  assign in_px.ready = in_ready;

  nnd_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .src_w    (src_w),
    .src_h    (src_h),
    .max_side (max_side),
    .pixel_in (in_px.pixel_in),
    .out_px   (out_px)
  );

endmodule

FILE: hdl/nnd_regs.sv
module nnd_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nnd_pkg::PADDR_W-1:0]   paddr,
  input  logic [nnd_pkg::PDATA_W-1:0]   pwdata,
  output logic [nnd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [nnd_pkg::REG_W-1:0]     src_w,
  output logic [nnd_pkg::REG_W-1:0]     src_h,
  output logic [nnd_pkg::REG_W-1:0]     max_side,
  output logic                          cfg_wr
);

  logic [nnd_pkg::REG_W-1:0] src_w_r, src_w_nxt;
  logic [nnd_pkg::REG_W-1:0] src_h_r, src_h_nxt;
  logic [nnd_pkg::REG_W-1:0] max_side_r, max_side_nxt;
  nnd_pkg::reg_idx_t         idx;

  assign idx    = nnd_pkg::reg_idx_t'(paddr[nnd_pkg::PADDR_W-1:2]);
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    src_w_nxt    = src_w_r;
    src_h_nxt    = src_h_r;
    max_side_nxt = max_side_r;
    if (cfg_wr) begin
      case (idx)
        nnd_pkg::REG_SRC_W:    src_w_nxt    = pwdata[nnd_pkg::REG_W-1:0];
        nnd_pkg::REG_SRC_H:    src_h_nxt    = pwdata[nnd_pkg::REG_W-1:0];
        nnd_pkg::REG_MAX_SIDE: max_side_nxt = pwdata[nnd_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      nnd_pkg::REG_SRC_W:    prdata = nnd_pkg::PDATA_W'(src_w_r);
      nnd_pkg::REG_SRC_H:    prdata = nnd_pkg::PDATA_W'(src_h_r);
      nnd_pkg::REG_MAX_SIDE: prdata = nnd_pkg::PDATA_W'(max_side_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r    <= nnd_pkg::REG_W'(1);
      src_h_r    <= nnd_pkg::REG_W'(1);
      max_side_r <= '0;
    end else begin
      src_w_r    <= src_w_nxt;
      src_h_r    <= src_h_nxt;
      max_side_r <= max_side_nxt;
    end
  end

  assign src_w    = src_w_r;
  assign src_h    = src_h_r;
  assign max_side = max_side_r;

endmodule

FILE: hdl/nnd_div.sv
module nnd_div #(
  parameter int NW = 30,
  parameter int DW = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    dsr_r, dsr_nxt;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_sub;
  logic             fits;

  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign fits    = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

FILE: hdl/nnd_ctrl.sv
module nnd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              cfg_wr,
  input  nnd_pkg::nnd_sts_t sts,
  output logic              in_ready,
  output nnd_pkg::nnd_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_START,
    S_DIV,
    S_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_RUN) && sts.out_free;
  assign accept   = in_ready && in_valid;

  always_comb begin
    cmd.size_load = (state_r == S_START) && in_valid && !cfg_wr;
    cmd.size_take = (state_r == S_DIV) && sts.div_done && !cfg_wr;
    cmd.px_accept = accept;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_START: begin
        if (in_valid && !cfg_wr) begin
          state_nxt = sts.pass_thru ? S_RUN : S_DIV;
        end
      end
      S_DIV: begin
        if (cfg_wr) begin
          state_nxt = S_START;
        end else if (sts.div_done) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (accept && sts.img_wrap) begin
          state_nxt = S_START;
        end else if (!accept && cfg_wr && sts.img_start) begin
          state_nxt = S_START;
        end
      end
      default: state_nxt = S_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.size_load |=> state_r == S_DIV || state_r == S_RUN)
    else $error("size load did not leave image start");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.px_accept |-> sts.out_free)
    else $error("beat taken while output register blocked");

endmodule

FILE: hdl/nnd_dp.sv
module nnd_dp #(
  parameter int MAX_DIM = nnd_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nnd_pkg::nnd_cmd_t           cmd,
  output nnd_pkg::nnd_sts_t           sts,
  input  logic [nnd_pkg::REG_W-1:0]   src_w,
  input  logic [nnd_pkg::REG_W-1:0]   src_h,
  input  logic [nnd_pkg::REG_W-1:0]   max_side,
  input  logic [nnd_pkg::PIX_W-1:0]   pixel_in,
  nnd_out_if.source                   out_px
);

  localparam int SW = $clog2(MAX_DIM + 1);
  localparam int RW = nnd_pkg::REG_W;
  localparam int CW = (SW > RW) ? SW : RW;
  localparam int TW = 2 * SW + 1;
  localparam int NW = SW + RW;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_DIM);

  logic [CW-1:0] w_c, h_c, ms_c, wk, hk;
  logic [SW-1:0] w, h, m, side_small, quot_sz;
  logic          pass, w_wide;
  logic [NW-1:0] dividend, quot;
  logic          div_done;

  logic [SW-1:0] in_col_r, in_col_nxt;
  logic [SW-1:0] in_row_r, in_row_nxt;
  logic [SW-1:0] out_col_r, out_col_nxt;
  logic [SW-1:0] out_row_r, out_row_nxt;
  logic [SW-1:0] out_w_r, out_w_nxt;
  logic [SW-1:0] out_h_r, out_h_nxt;
  logic [TW-1:0] col_x_r, col_x_nxt;
  logic [TW-1:0] row_x_r, row_x_nxt;
  logic [TW-1:0] next_col_r, next_col_nxt;
  logic [TW-1:0] next_row_r, next_row_nxt;
  logic          row_sel_r, row_sel_nxt;
  logic          w_wide_r, w_wide_nxt;
  logic          ov_r, ov_nxt;
  logic [nnd_pkg::PIX_W-1:0] pix_r;
  logic          last_r;

  logic [SW:0]   in_col_inc, in_row_inc, oc_inc, or_inc;
  logic          col_wrap, row_wrap, row_sel_new, row_sel, emit, last;

  // clamp sides and decide scaling
  always_comb begin
    w_c  = CW'(src_w);
    h_c  = CW'(src_h);
    ms_c = CW'(max_side);
    wk   = (w_c == '0) ? CW'(1) : ((w_c > MAX_C) ? MAX_C : w_c);
    hk   = (h_c == '0) ? CW'(1) : ((h_c > MAX_C) ? MAX_C : h_c);
    w    = wk[SW-1:0];
    h    = hk[SW-1:0];
    pass = (ms_c == '0) || ((wk <= ms_c) && (hk <= ms_c));
    w_wide     = wk >= hk;
    m          = w_wide ? w : h;
    side_small = w_wide ? h : w;
    dividend   = NW'(side_small) * NW'(max_side);
    quot_sz    = (quot == '0) ? SW'(1) : quot[SW-1:0];
  end

  nnd_div #(
    .NW (NW),
    .DW (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.size_load),
    .dividend (dividend),
    .divisor  (m),
    .done     (div_done),
    .quot     (quot)
  );

  // per-pixel selection
  always_comb begin
    in_col_inc  = {1'b0, in_col_r} + (SW+1)'(1);
    in_row_inc  = {1'b0, in_row_r} + (SW+1)'(1);
    oc_inc      = {1'b0, out_col_r} + (SW+1)'(1);
    or_inc      = {1'b0, out_row_r} + (SW+1)'(1);
    col_wrap    = in_col_inc >= {1'b0, w};
    row_wrap    = in_row_inc >= {1'b0, h};
    row_sel_new = (out_row_r < out_h_r) && (next_row_r < row_x_r + TW'(out_h_r));
    row_sel     = (in_col_r == '0) ? row_sel_new : row_sel_r;
    emit        = row_sel && (out_col_r < out_w_r) &&
                  (next_col_r < col_x_r + TW'(out_w_r));
    last        = (oc_inc == {1'b0, out_w_r}) && (or_inc == {1'b0, out_h_r});
  end

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_w_nxt    = out_w_r;
    out_h_nxt    = out_h_r;
    col_x_nxt    = col_x_r;
    row_x_nxt    = row_x_r;
    next_col_nxt = next_col_r;
    next_row_nxt = next_row_r;
    row_sel_nxt  = row_sel_r;
    w_wide_nxt   = w_wide_r;

    if (cmd.size_load) begin
      w_wide_nxt = w_wide;
      if (pass) begin
        out_w_nxt = w;
        out_h_nxt = h;
      end else if (w_wide) begin
        out_w_nxt = ms_c[SW-1:0];
      end else begin
        out_h_nxt = ms_c[SW-1:0];
      end
    end

    if (cmd.size_take) begin
      if (w_wide_r) begin
        out_h_nxt = quot_sz;
      end else begin
        out_w_nxt = quot_sz;
      end
    end

    if (cmd.px_accept) begin
      if (emit) begin
        out_col_nxt  = oc_inc[SW-1:0];
        next_col_nxt = next_col_r + TW'(w);
      end
      col_x_nxt   = col_x_r + TW'(out_w_r);
      in_col_nxt  = in_col_inc[SW-1:0];
      row_sel_nxt = row_sel;
      if (col_wrap) begin
        in_col_nxt   = '0;
        col_x_nxt    = '0;
        out_col_nxt  = '0;
        next_col_nxt = '0;
        if (row_sel) begin
          out_row_nxt  = or_inc[SW-1:0];
          next_row_nxt = next_row_r + TW'(h);
        end
        row_sel_nxt = 1'b0;
        row_x_nxt   = row_x_r + TW'(out_h_r);
        in_row_nxt  = in_row_inc[SW-1:0];
        if (row_wrap) begin
          in_row_nxt   = '0;
          row_x_nxt    = '0;
          out_row_nxt  = '0;
          next_row_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (cmd.px_accept && emit) begin
      ov_nxt = 1'b1;
    end else if (out_px.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_w_r    <= '0;
      out_h_r    <= '0;
      col_x_r    <= '0;
      row_x_r    <= '0;
      next_col_r <= '0;
      next_row_r <= '0;
      row_sel_r  <= 1'b0;
      w_wide_r   <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_w_r    <= out_w_nxt;
      out_h_r    <= out_h_nxt;
      col_x_r    <= col_x_nxt;
      row_x_r    <= row_x_nxt;
      next_col_r <= next_col_nxt;
      next_row_r <= next_row_nxt;
      row_sel_r  <= row_sel_nxt;
      w_wide_r   <= w_wide_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.px_accept && emit) begin
      pix_r  <= pixel_in;
      last_r <= last;
    end
  end

  assign out_px.valid         = ov_r;
  assign out_px.pixel_out     = pix_r;
  assign out_px.last_of_image = last_r;

  always_comb begin
    sts.img_start = (in_col_r == '0) && (in_row_r == '0);
    sts.img_wrap  = col_wrap && row_wrap;
    sts.pass_thru = pass;
    sts.div_done  = div_done;
    sts.out_free  = !ov_r || out_px.ready;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_col_r <= out_w_r)
    else $error("output column ran past latched width");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_row_r <= out_h_r)
    else $error("output row ran past latched height");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r == '0 |-> (out_col_r == '0 && col_x_r == '0 && next_col_r == '0))
    else $error("column trackers not cleared at row start");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.size_load || cmd.size_take) |-> (in_col_r == '0 && in_row_r == '0))
    else $error("output size changed inside an image");

endmodule
